### rtl/cubic_hermite_curve_point_unit_defines.svh
// Assertion macros shared by the curve point unit RTL.
`ifndef CUBIC_HERMITE_CURVE_POINT_UNIT_DEFINES_SVH
`define CUBIC_HERMITE_CURVE_POINT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define CHCP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("%m: check failed");
// Antecedent in this cycle requires the consequent in the next one.
`define CHCP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define CHCP_ASSERT(lbl, prop)
`define CHCP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/chcp_pkg.sv
// Shared constants and types of the cubic Hermite curve point unit.
package chcp_pkg;

    // Curve parameter: t = step_index / 2**STEPS_LOG2
    localparam int STEPS_LOG2 = 10;
    localparam int SQR_SH     = 2 * STEPS_LOG2;
    localparam int CUBE_SH    = 3 * STEPS_LOG2;

    // Field widths
    localparam int IDX_W   = 11;
    localparam int COORD_W = 12;
    localparam int TAN_W   = 15;
    localparam int OUT_W   = 19;

    // Stream bus widths (whole bytes)
    localparam int IN_TDATA_W  = ((IDX_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;

    // Datapath widths: coefficient, Horner partial sums, rounding word
    localparam int COEF_W = 17;
    localparam int MIDX_W = IDX_W + 1;
    localparam int H1_W   = COEF_W + MIDX_W;
    localparam int H2_W   = H1_W + MIDX_W;
    localparam int H3_W   = H2_W + MIDX_W;
    localparam int RND_W  = H3_W + 1;
    localparam int RQ_W   = RND_W - CUBE_SH;

    // Pipeline depth: index, coefficients, three Horner steps, rounding
    localparam int NUM_STAGES = 6;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = TAN_W;

    localparam logic [CFG_IDX_W-1:0] REG_START_X         = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_START_Y         = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_START_TANGENT_X = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_START_TANGENT_Y = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_END_X           = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_END_Y           = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_END_TANGENT_X   = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_END_TANGENT_Y   = CFG_IDX_W'(7);

    // Control points and tangents of one axis
    typedef struct packed {
        logic        [COORD_W-1:0] p1;
        logic signed [TAN_W-1:0]   t1;
        logic        [COORD_W-1:0] p2;
        logic signed [TAN_W-1:0]   t2;
    } t_axis_cfg;

    // Per-stage load strobes from the pipeline control
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } t_pipe_ctl;

endpackage

### rtl/chcp_cfg.sv
// Configuration registers: curve end points and tangents for both axes.
module chcp_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [chcp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [chcp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output chcp_pkg::t_axis_cfg                o_cfg_x,
    output chcp_pkg::t_axis_cfg                o_cfg_y
);
    import chcp_pkg::*;

    t_axis_cfg r_cfg_x;
    t_axis_cfg r_cfg_y;

    // Register write, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_x <= '0;
            r_cfg_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_START_X:         r_cfg_x.p1 <= i_cfg_wdata[COORD_W-1:0];
                REG_START_Y:         r_cfg_y.p1 <= i_cfg_wdata[COORD_W-1:0];
                REG_START_TANGENT_X: r_cfg_x.t1 <= $signed(i_cfg_wdata[TAN_W-1:0]);
                REG_START_TANGENT_Y: r_cfg_y.t1 <= $signed(i_cfg_wdata[TAN_W-1:0]);
                REG_END_X:           r_cfg_x.p2 <= i_cfg_wdata[COORD_W-1:0];
                REG_END_Y:           r_cfg_y.p2 <= i_cfg_wdata[COORD_W-1:0];
                REG_END_TANGENT_X:   r_cfg_x.t2 <= $signed(i_cfg_wdata[TAN_W-1:0]);
                REG_END_TANGENT_Y:   r_cfg_y.t2 <= $signed(i_cfg_wdata[TAN_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_x = r_cfg_x;
    assign o_cfg_y = r_cfg_y;

endmodule

### rtl/chcp_ctrl.sv
// Pipeline control: valid bits per stage and the bubble-collapsing ready chain.
`include "cubic_hermite_curve_point_unit_defines.svh"
module chcp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output chcp_pkg::t_pipe_ctl  o_ctl
);
    import chcp_pkg::*;

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    logic [NUM_STAGES:0]   ready;

    // A stage may load when it is empty or its item moves on
    always_comb begin
        ready[NUM_STAGES] = i_m_tready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            ready[k] = !r_valid[k] || ready[k+1];
        end
    end

    // Valid bits follow the data; a loading stage takes its upstream bit
    always_comb begin
        n_valid = r_valid;
        if (ready[0]) begin
            n_valid[0] = i_s_tvalid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (ready[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ctl.load = ready[NUM_STAGES-1:0];
    assign o_s_tready = ready[0];
    assign o_m_tvalid = r_valid[NUM_STAGES-1];

    // Input is refused only while every stage holds an item
    `CHCP_ASSERT(a_full_when_blocked, !o_s_tready |-> (&r_valid))
    // An accepted beat lands in the first stage
    `CHCP_ASSERT_NEXT(a_accept_fills, i_s_tvalid && o_s_tready, r_valid[0])
    // A full pipe under output stall keeps all its items
    `CHCP_ASSERT_NEXT(a_stall_freezes, (&r_valid) && !i_m_tready, &r_valid)

endmodule

### rtl/chcp_axis.sv
// One axis of the curve: coefficients, three Horner steps and rounding.
module chcp_axis (
    input  logic                           i_clk,
    input  chcp_pkg::t_pipe_ctl            i_ctl,
    input  chcp_pkg::t_axis_cfg            i_cfg,
    input  logic [chcp_pkg::IDX_W-1:0]     i_idx,
    output logic signed [chcp_pkg::OUT_W-1:0] o_pixel
);
    import chcp_pkg::*;

    localparam logic signed [RND_W-1:0] HALF = RND_W'(1) <<< (CUBE_SH - 1);
    localparam logic signed [RND_W-1:0] BIAS = (RND_W'(1) <<< CUBE_SH) - RND_W'(1);
    localparam logic signed [RQ_W-1:0]  OUT_MIN_Q = -(RQ_W'(1) <<< (OUT_W - 1));
    localparam logic signed [RQ_W-1:0]  OUT_MAX_Q = (RQ_W'(1) <<< (OUT_W - 1)) - RQ_W'(1);

    logic [IDX_W-1:0]               r0_idx;
    logic [IDX_W-1:0]               r1_idx;
    logic [IDX_W-1:0]               r2_idx;
    logic [IDX_W-1:0]               r3_idx;
    logic signed [COEF_W-1:0]       r1_c2;
    logic signed [COEF_W-1:0]       r1_c3;
    logic signed [H1_W-1:0]         r2_h1;
    logic signed [H2_W-1:0]         r3_h2;
    logic signed [H3_W-1:0]         r4_h3;
    logic signed [OUT_W-1:0]        r5_pix;

    logic signed [COEF_W-1:0]       p1_e;
    logic signed [COEF_W-1:0]       p2_e;
    logic signed [COEF_W-1:0]       t1_e;
    logic signed [COEF_W-1:0]       t2_e;
    logic signed [COEF_W-1:0]       diff;
    logic signed [COEF_W-1:0]       n_c2;
    logic signed [COEF_W-1:0]       n_c3;
    logic signed [MIDX_W-1:0]       idx1_s;
    logic signed [MIDX_W-1:0]       idx2_s;
    logic signed [MIDX_W-1:0]       idx3_s;
    logic signed [H1_W-1:0]         n_h1;
    logic signed [H2_W-1:0]         n_h2;
    logic signed [H3_W-1:0]         n_h3;
    logic signed [RND_W-1:0]        rnd;
    logic signed [RND_W-1:0]        rnd_adj;
    logic signed [RQ_W-1:0]         quo;
    logic signed [OUT_W-1:0]        n_pix;

    // Quadratic and cubic coefficients: c2 = 3d - 2t1 - t2, c3 = t1 + t2 - 2d
    always_comb begin
        p1_e = COEF_W'($signed({1'b0, i_cfg.p1}));
        p2_e = COEF_W'($signed({1'b0, i_cfg.p2}));
        t1_e = COEF_W'($signed(i_cfg.t1));
        t2_e = COEF_W'($signed(i_cfg.t2));
        diff = p2_e - p1_e;
        n_c2 = (diff <<< 1) + diff - (t1_e <<< 1) - t2_e;
        n_c3 = t1_e + t2_e - (diff <<< 1);
    end

    // Horner steps in integer form, scaled by the step count
    assign idx1_s = $signed({1'b0, r1_idx});
    assign idx2_s = $signed({1'b0, r2_idx});
    assign idx3_s = $signed({1'b0, r3_idx});
    assign n_h1 = r1_c3 * idx1_s + (H1_W'(r1_c2) <<< STEPS_LOG2);
    assign n_h2 = r2_h1 * idx2_s + (H2_W'($signed(i_cfg.t1)) <<< SQR_SH);
    assign n_h3 = r3_h2 * idx3_s + (H3_W'($signed({1'b0, i_cfg.p1})) <<< CUBE_SH);

    // Add one half, divide rounding toward zero, then saturate
    always_comb begin
        rnd     = RND_W'(r4_h3) + HALF;
        rnd_adj = rnd[RND_W-1] ? (rnd + BIAS) : rnd;
        quo     = rnd_adj[RND_W-1:CUBE_SH];
        if (quo < OUT_MIN_Q) begin
            n_pix = OUT_MIN_Q[OUT_W-1:0];
        end else if (quo > OUT_MAX_Q) begin
            n_pix = OUT_MAX_Q[OUT_W-1:0];
        end else begin
            n_pix = quo[OUT_W-1:0];
        end
    end

    // Stage registers, each loads on its own strobe
    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r0_idx <= i_idx;
        end
        if (i_ctl.load[1]) begin
            r1_idx <= r0_idx;
            r1_c2  <= n_c2;
            r1_c3  <= n_c3;
        end
        if (i_ctl.load[2]) begin
            r2_idx <= r1_idx;
            r2_h1  <= n_h1;
        end
        if (i_ctl.load[3]) begin
            r3_idx <= r2_idx;
            r3_h2  <= n_h2;
        end
        if (i_ctl.load[4]) begin
            r4_h3 <= n_h3;
        end
        if (i_ctl.load[5]) begin
            r5_pix <= n_pix;
        end
    end

    assign o_pixel = r5_pix;

endmodule

### rtl/cubic_hermite_curve_point_unit.sv
// Top level of the cubic Hermite curve point unit.
//
// Usage: load the start point, start tangent, end point and end tangent of
// each axis through the write port (index 0..7, low bits kept, other indexes
// ignored) while no beat is in flight. Each input beat carries a step index
// i; the unit returns the pixel at t = i / 1024, rounded half up and then
// truncated toward zero, saturated to 19-bit two's complement.
// Channels: slave stream in (step index), master stream out (x, y).
// Path: each beat passes the index, coefficient, Horner and rounding stages.
// Throughput: one beat per clock unless the receiver stalls, set by a
// six-stage pipeline with one narrow multiplier per Horner step and axis.
// Reset clears the configuration to zero and empties the pipeline.
// Receiver stall: stages hold their items and bubbles close up; the input
// stays ready until all six stages are occupied.
module cubic_hermite_curve_point_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [chcp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [chcp_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // input stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [chcp_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,  // step_index
    // output stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [chcp_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata   // pixel_x, pixel_y
);
    import chcp_pkg::*;

    t_axis_cfg               cfg_x;
    t_axis_cfg               cfg_y;
    t_pipe_ctl               ctl;
    logic signed [OUT_W-1:0] pixel_x;
    logic signed [OUT_W-1:0] pixel_y;

    chcp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg_x     (cfg_x),
        .o_cfg_y     (cfg_y)
    );

    chcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_ctl      (ctl)
    );

    chcp_axis u_axis_x (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_cfg   (cfg_x),
        .i_idx   (i_s_axis_tdata[IDX_W-1:0]),
        .o_pixel (pixel_x)
    );

    chcp_axis u_axis_y (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_cfg   (cfg_y),
        .i_idx   (i_s_axis_tdata[IDX_W-1:0]),
        .o_pixel (pixel_y)
    );

    // Output beat: x in the low bits, y above, zero padding on top
    assign o_m_axis_tdata = {{(OUT_TDATA_W - 2 * OUT_W){1'b0}}, pixel_y, pixel_x};

endmodule

### tb/tb_cubic_hermite_curve_point_unit.sv
// Self-checking testbench for the cubic Hermite curve point unit.
`timescale 1ns / 1ps

module tb_cubic_hermite_curve_point_unit;
    import chcp_pkg::*;

    localparam int NUM_CURVE_REGS = REG_END_TANGENT_Y + 1;
    localparam int QUIET_LIMIT    = 2000;
    localparam longint OUT_LO     = -(longint'(1) << (OUT_W - 1));
    localparam longint OUT_HI     = (longint'(1) << (OUT_W - 1)) - 1;

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
    } t_curve_pixel;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Shadow copy of the curve registers, raw bits as the unit keeps them
    logic [CFG_DATA_W-1:0]  curve_reg [NUM_CURVE_REGS] = '{default: '0};
    t_curve_pixel           pixel_due_q[$];
    t_curve_pixel           due_px;

    int src_gap_max  = 0;
    int sink_max     = 0;
    int sink_hold    = 0;
    int sink_draw    = 0;
    int quiet_cycles = 0;
    int fail_count   = 0;
    int steps_sent   = 0;
    int pixels_seen  = 0;
    int curves_used  = 0;

    cubic_hermite_curve_point_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // step_index
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)    // pixel_x, pixel_y
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Curve prediction
    // ---------------------------------------------------------------
    function automatic bit is_tangent(input logic [CFG_IDX_W-1:0] idx);
        return idx == REG_START_TANGENT_X || idx == REG_START_TANGENT_Y ||
               idx == REG_END_TANGENT_X   || idx == REG_END_TANGENT_Y;
    endfunction

    function automatic longint reg_val(input logic [CFG_IDX_W-1:0] idx);
        if (is_tangent(idx))
            return longint'($signed(curve_reg[idx][TAN_W-1:0]));
        return longint'(curve_reg[idx][COORD_W-1:0]);
    endfunction

    // One axis, exact over denominator STEPS^3, rounded trunc(v + 0.5)
    function automatic logic signed [OUT_W-1:0] hermite_coord(
        input longint p1, input longint v1, input longint p2, input longint v2,
        input longint i);
        longint s, s3, c2, c3, num, r;
        s   = longint'(1) << STEPS_LOG2;
        s3  = s * s * s;
        c2  = -3 * p1 - 2 * v1 + 3 * p2 - v2;
        c3  = 2 * p1 + v1 - 2 * p2 + v2;
        num = p1 * s3 + v1 * i * s * s + c2 * i * i * s + c3 * i * i * i;
        r   = (2 * num + s3) / (2 * s3);
        if (r < OUT_LO) r = OUT_LO;
        if (r > OUT_HI) r = OUT_HI;
        return r[OUT_W-1:0];
    endfunction

    function automatic t_curve_pixel curve_pixel(input logic [IDX_W-1:0] idx);
        t_curve_pixel px;
        px.x = hermite_coord(reg_val(REG_START_X), reg_val(REG_START_TANGENT_X),
                             reg_val(REG_END_X), reg_val(REG_END_TANGENT_X), longint'(idx));
        px.y = hermite_coord(reg_val(REG_START_Y), reg_val(REG_START_TANGENT_Y),
                             reg_val(REG_END_Y), reg_val(REG_END_TANGENT_Y), longint'(idx));
        return px;
    endfunction

    // ---------------------------------------------------------------
    // Shared tasks
    // ---------------------------------------------------------------
    // Leaves the write enable high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx < NUM_CURVE_REGS)
            curve_reg[idx] = is_tangent(idx) ? val : CFG_DATA_W'(val[COORD_W-1:0]);
    endtask

    // Leaves tvalid high so a back-to-back beat needs no second assignment
    task automatic send_step(input logic [IDX_W-1:0] idx);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(idx);
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pixel_due_q.push_back(curve_pixel(idx));
        steps_sent++;
    endtask

    // Stop sending and wait until every pending pixel has come back
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pixel_due_q.size() != 0) @(posedge clk);
        repeat (NUM_STAGES + 2) @(posedge clk);
    endtask

    // Curve register value: extremes often, small tangents sometimes, random otherwise (excess bits random)
    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input logic [CFG_IDX_W-1:0] idx);
        int sel;
        sel = $urandom_range(0, 5);
        if (is_tangent(idx)) begin
            case (sel)
                0: return {1'b0, {(TAN_W-1){1'b1}}};
                1: return {1'b1, {(TAN_W-1){1'b0}}};
                2: return CFG_DATA_W'($signed($urandom_range(0, 64)) - 32);
                default: return CFG_DATA_W'($urandom);
            endcase
        end
        case (sel)
            0: return {(CFG_DATA_W-COORD_W)'($urandom), {COORD_W{1'b0}}};
            1: return {(CFG_DATA_W-COORD_W)'($urandom), {COORD_W{1'b1}}};
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Receiver: per-beat random stall
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold > 0) begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if (m_tready && m_tvalid) begin
            sink_draw = $urandom_range(0, sink_max);
            m_tready  <= (sink_draw == 0);
            sink_hold <= (sink_draw == 0) ? 0 : sink_draw - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Result check against the oldest pending pixel
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            pixels_seen++;
            if (pixel_due_q.size() == 0) begin
                $error("unexpected pixel beat: x %0d y %0d",
                       $signed(m_tdata[OUT_W-1:0]), $signed(m_tdata[2*OUT_W-1:OUT_W]));
                fail_count++;
            end else begin
                due_px = pixel_due_q.pop_front();
                if (m_tdata[OUT_W-1:0] !== due_px.x) begin
                    $error("pixel_x: expected %0d, got %0d",
                           due_px.x, $signed(m_tdata[OUT_W-1:0]));
                    fail_count++;
                end
                if (m_tdata[2*OUT_W-1:OUT_W] !== due_px.y) begin
                    $error("pixel_y: expected %0d, got %0d",
                           due_px.y, $signed(m_tdata[2*OUT_W-1:OUT_W]));
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long without any beat on either stream
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("cubic_hermite_curve_point_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // All registers clear after reset: every point is the origin
    task automatic test_reset_defaults;
        src_gap_max = 0;
        sink_max    = 0;
        send_step('0);
        send_step({IDX_W{1'b1}});
        drain();
    endtask

    // Extreme control points and tangents, index extremes and single-bit walk
    task automatic test_directed_extremes;
        src_gap_max = 14;
        sink_max    = 14;
        write_reg(REG_START_X,         '0);
        write_reg(REG_START_Y,         CFG_DATA_W'({COORD_W{1'b1}}));
        write_reg(REG_START_TANGENT_X, {1'b0, {(TAN_W-1){1'b1}}});
        write_reg(REG_START_TANGENT_Y, {1'b1, {(TAN_W-1){1'b0}}});
        write_reg(REG_END_X,           CFG_DATA_W'({COORD_W{1'b1}}));
        write_reg(REG_END_Y,           '0);
        write_reg(REG_END_TANGENT_X,   {1'b1, {(TAN_W-1){1'b0}}});
        write_reg(REG_END_TANGENT_Y,   {1'b0, {(TAN_W-1){1'b1}}});
        cfg_we <= 1'b0;
        curves_used++;
        // end of curve, just past it, and the farthest extrapolation
        send_step(IDX_W'(1 << STEPS_LOG2));
        send_step(IDX_W'((1 << STEPS_LOG2) + 1));
        send_step({IDX_W{1'b1}});
        for (int k = 0; k < IDX_W; k++)
            send_step(IDX_W'(1) << k);
        drain();

        // Tiny negative tangent: values in (-1, 0) must round toward zero
        write_reg(REG_START_X,         '0);
        write_reg(REG_START_TANGENT_X, '1);
        write_reg(REG_END_X,           '0);
        write_reg(REG_END_TANGENT_X,   '0);
        cfg_we <= 1'b0;
        curves_used++;
        send_step(IDX_W'(256));
        send_step(IDX_W'(512));
        send_step(IDX_W'(768));
        drain();
    endtask

    // Writes past the last register are dropped; excess high bits are cut off
    task automatic test_register_handling;
        src_gap_max = 3;
        sink_max    = 3;
        for (int k = 0; k < NUM_CURVE_REGS; k++)
            write_reg(CFG_IDX_W'(k), '1);
        for (int k = NUM_CURVE_REGS; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        curves_used++;
        send_step('0);
        send_step(IDX_W'(1 << (STEPS_LOG2 - 1)));
        send_step(IDX_W'(1 << STEPS_LOG2));
        drain();
    endtask

    // Random curves with random step indexes and random idling per curve
    task automatic test_random_curves(input int num_curves, input int steps_per_curve);
        int sel;
        logic [IDX_W-1:0] idx;
        for (int c = 0; c < num_curves; c++) begin
            for (int k = 0; k < NUM_CURVE_REGS; k++) begin
                // mostly a fresh value; sometimes the old one is kept
                if (c == 0 || $urandom_range(0, 7) != 0)
                    write_reg(CFG_IDX_W'(k), pick_reg_value(CFG_IDX_W'(k)));
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(NUM_CURVE_REGS, (1 << CFG_IDX_W) - 1)),
                          CFG_DATA_W'($urandom));
            cfg_we <= 1'b0;
            curves_used++;

            sel = $urandom_range(0, 3);
            src_gap_max = (sel == 1 || sel == 3) ? 14 : 0;
            sink_max    = (sel == 2 || sel == 3) ? 14 : 0;

            for (int n = 0; n < steps_per_curve; n++) begin
                case ($urandom_range(0, 9))
                    0:       idx = $urandom_range(0, 1) ? IDX_W'(1 << STEPS_LOG2) : '0;
                    7, 8:    idx = IDX_W'($urandom_range((1 << STEPS_LOG2) + 1, (1 << IDX_W) - 1));
                    9:       idx = IDX_W'($urandom);
                    default: idx = IDX_W'($urandom_range(0, 1 << STEPS_LOG2));
                endcase
                send_step(idx);
                // on every third curve, hold off mid-curve until the pipeline is empty
                if (n == steps_per_curve / 2 && (c % 3) == 0)
                    drain();
            end
            drain();
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_extremes();
        test_register_handling();
        test_random_curves(21, 40);

        drain();
        $display("Checked %0d pixels from %0d step indexes (0 to 2047) over %0d curve settings,",
                 pixels_seen, steps_sent, curves_used);
        $display("with extreme and random points and tangents, random stalls on both streams.");
        if (fail_count == 0)
            $display("cubic_hermite_curve_point_unit verification clean");
        else
            $display("cubic_hermite_curve_point_unit verification failed");
        $finish;
    end

endmodule
